@@ rtl/core/lpc_pkg.sv @@
`default_nettype none

package lpc_pkg;

  // Default table geometry.
  localparam int DefEntries = 8;
  localparam int DefKeyBits = 16;

  // Fixed field widths of the ports.
  localparam int PageBits = 16;
  localparam int CapBits  = 4;
  localparam int OccBits  = 4;

  // Capacity after reset.
  localparam logic [CapBits-1:0] CapReset = 4'd5;

  // Outcome of one lookup, passed from the lookup logic to the table.
  typedef struct packed {
    logic hit;
    logic evict;
  } lpc_op_t;

endpackage

`default_nettype wire

@@ rtl/core/lpc_lookup.sv @@
`default_nettype none

module lpc_lookup #(
  parameter int ENTRIES  = lpc_pkg::DefEntries,
  parameter int KEY_BITS = lpc_pkg::DefKeyBits
) (
  input  logic [KEY_BITS-1:0]                         key_i,
  input  logic [lpc_pkg::CapBits-1:0]                 capacity_i,
  input  logic [ENTRIES-1:0]                          valid_i,
  input  logic [ENTRIES-1:0][KEY_BITS-1:0]            keys_i,
  input  logic [ENTRIES-1:0][$clog2(ENTRIES)-1:0]     ranks_i,
  input  logic [$clog2(ENTRIES+1)-1:0]                count_i,
  output lpc_pkg::lpc_op_t                            op_o,
  output logic [ENTRIES-1:0]                          sel_oh_o,
  output logic [$clog2(ENTRIES+1)-1:0]                limit_o,
  output logic [KEY_BITS-1:0]                         evicted_key_o
);
  import lpc_pkg::*;

  localparam int RankBits = $clog2(ENTRIES);
  localparam int CntBits  = $clog2(ENTRIES + 1);
  localparam int CmpBits  = (CntBits > CapBits) ? CntBits : CapBits;

  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  hit_oh;
  logic [ENTRIES-1:0]  free_oh;
  logic [ENTRIES-1:0]  lru_oh;
  logic [RankBits-1:0] hit_rank;
  logic [KEY_BITS-1:0] lru_key;
  logic [CmpBits-1:0]  cap_ext;
  logic [CmpBits-1:0]  eff_cap;
  logic                full;
  logic [CntBits-1:0]  oldest_rank;

  // Parallel key compare against every resident entry.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_i[i] && (keys_i[i] == key_i);
    end
  end

  // Lowest-numbered match and lowest-numbered free entry.
  assign hit_oh  = match & (~match + ENTRIES'(1));
  assign free_oh = ~valid_i & (valid_i + ENTRIES'(1));

  // The least recent entry holds the rank one below the resident count.
  assign oldest_rank = count_i - CntBits'(1);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lru_oh[i] = valid_i[i] && (CntBits'(ranks_i[i]) == oldest_rank);
    end
  end

  // Gather the rank of the hit entry and the key of the least recent entry.
  always_comb begin
    hit_rank = '0;
    lru_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh[i]) begin
        hit_rank = hit_rank | ranks_i[i];
      end
      if (lru_oh[i]) begin
        lru_key = lru_key | keys_i[i];
      end
    end
  end

  // Capacity of zero acts as one; capacity above the table size saturates.
  assign cap_ext = CmpBits'(capacity_i);

  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CmpBits'(1);
    end
    if (cap_ext > CmpBits'(ENTRIES)) begin
      eff_cap = CmpBits'(ENTRIES);
    end
  end

  assign full = CmpBits'(count_i) >= eff_cap;

  // Pick the entry to promote or fill and the aging limit.
  always_comb begin
    op_o.hit      = |match;
    op_o.evict    = !(|match) && full;
    sel_oh_o      = free_oh;
    limit_o       = CntBits'(ENTRIES);
    evicted_key_o = '0;
    if (|match) begin
      sel_oh_o = hit_oh;
      limit_o  = CntBits'(hit_rank);
    end else if (full) begin
      sel_oh_o      = lru_oh;
      limit_o       = oldest_rank;
      evicted_key_o = lru_key;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lpc_table.sv @@
`default_nettype none

module lpc_table #(
  parameter int ENTRIES  = lpc_pkg::DefEntries,
  parameter int KEY_BITS = lpc_pkg::DefKeyBits
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        upd_i,
  input  lpc_pkg::lpc_op_t                            op_i,
  input  logic [ENTRIES-1:0]                          sel_oh_i,
  input  logic [$clog2(ENTRIES+1)-1:0]                limit_i,
  input  logic [KEY_BITS-1:0]                         key_i,
  output logic [ENTRIES-1:0]                          valid_o,
  output logic [ENTRIES-1:0][KEY_BITS-1:0]            keys_o,
  output logic [ENTRIES-1:0][$clog2(ENTRIES)-1:0]     ranks_o,
  output logic [$clog2(ENTRIES+1)-1:0]                count_o,
  output logic [$clog2(ENTRIES+1)-1:0]                count_next_o
);
  import lpc_pkg::*;

  localparam int RankBits = $clog2(ENTRIES);
  localparam int CntBits  = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0]                valid_q, valid_d;
  logic [ENTRIES-1:0][RankBits-1:0]  rank_q, rank_d;
  logic [ENTRIES-1:0][KEY_BITS-1:0]  key_q;
  logic [CntBits-1:0]                count_q, count_d;
  logic                              insert;

  assign insert = upd_i && !op_i.hit && !op_i.evict;

  // Age every resident entry below the limit, then make the selected one newest.
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (upd_i) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (CntBits'(rank_q[i]) < limit_i)) begin
          rank_d[i] = rank_q[i] + RankBits'(1);
        end
        if (sel_oh_i[i]) begin
          rank_d[i]  = '0;
          valid_d[i] = 1'b1;
        end
      end
    end
  end

  assign count_d = insert ? count_q + CntBits'(1) : count_q;

  // Control state: valid bits, ranks and resident count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      count_q <= count_d;
    end
  end

  // Stored keys are written on a miss into the selected entry.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (upd_i && !op_i.hit && sel_oh_i[i]) begin
        key_q[i] <= key_i;
      end
    end
  end

  assign valid_o      = valid_q;
  assign keys_o       = key_q;
  assign ranks_o      = rank_q;
  assign count_o      = count_q;
  assign count_next_o = count_d;

  // The resident count always equals the number of valid entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(count_q))
    else $error("resident count differs from valid entries");

  // Every reference selects exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i |-> $onehot(sel_oh_i))
    else $error("reference did not select exactly one entry");

  // A plain insert grows the table by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    insert |=> count_q == $past(count_q) + CntBits'(1))
    else $error("insert did not grow the resident count");

endmodule

`default_nettype wire

@@ rtl/core/lru_page_cache_table_core.sv @@
`default_nettype none

// A reference is held in the input register and its result word in the result register;
// a result word is delayed while an earlier result word has not yet been taken by the receiver.
// Throughput: one reference per clock while result words are taken; the key compare and rank
// update over the table are done combinationally between the input register and the result register.
// Reset (asynchronous, active low) empties the table, clears the valid flags of both registers
// and sets the capacity to 5.

module lru_page_cache_table_core #(
  parameter int ENTRIES  = lpc_pkg::DefEntries,
  parameter int KEY_BITS = lpc_pkg::DefKeyBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpc_pkg::CapBits-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lpc_pkg::PageBits-1:0]  page_number_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic                          evicted_o,
  output logic [lpc_pkg::PageBits-1:0]  evicted_page_o,
  output logic [lpc_pkg::OccBits-1:0]   occupancy_o
);
  import lpc_pkg::*;

  localparam int RankBits = $clog2(ENTRIES);
  localparam int CntBits  = $clog2(ENTRIES + 1);

  logic [CapBits-1:0]                capacity_q;
  logic                              in_valid_q;
  logic [KEY_BITS-1:0]               key_q;
  logic                              proc;

  logic                              out_valid_q;
  logic                              hit_q;
  logic                              evicted_q;
  logic [PageBits-1:0]               evicted_page_q;
  logic [OccBits-1:0]                occupancy_q;

  lpc_op_t                           op;
  logic [ENTRIES-1:0]                sel_oh;
  logic [CntBits-1:0]                limit;
  logic [KEY_BITS-1:0]               evicted_key;
  logic [ENTRIES-1:0]                valid;
  logic [ENTRIES-1:0][KEY_BITS-1:0]  keys;
  logic [ENTRIES-1:0][RankBits-1:0]  ranks;
  logic [CntBits-1:0]                count;
  logic [CntBits-1:0]                count_next;

  // A held reference is processed whenever the result register is free or draining.
  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      key_q <= KEY_BITS'(page_number_i);
    end
  end

  lpc_lookup #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_lookup (
    .key_i         (key_q),
    .capacity_i    (capacity_q),
    .valid_i       (valid),
    .keys_i        (keys),
    .ranks_i       (ranks),
    .count_i       (count),
    .op_o          (op),
    .sel_oh_o      (sel_oh),
    .limit_o       (limit),
    .evicted_key_o (evicted_key)
  );

  lpc_table #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (proc),
    .op_i         (op),
    .sel_oh_i     (sel_oh),
    .limit_i      (limit),
    .key_i        (key_q),
    .valid_o      (valid),
    .keys_o       (keys),
    .ranks_o      (ranks),
    .count_o      (count),
    .count_next_o (count_next)
  );

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result word payload.
  always_ff @(posedge clk_i) begin
    if (proc) begin
      hit_q          <= op.hit;
      evicted_q      <= op.evict;
      evicted_page_q <= PageBits'(evicted_key);
      occupancy_q    <= OccBits'(count_next);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign evicted_o      = evicted_q;
  assign evicted_page_o = evicted_page_q;
  assign occupancy_o    = occupancy_q;

  // A processed reference always leaves a result word behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("processed reference produced no result word");

  // No page is reported unless an eviction took place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !evicted_q) |-> (evicted_page_q == '0))
    else $error("evicted page reported without eviction");

  // A hit never evicts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(hit_q && evicted_q))
    else $error("hit and eviction reported together");

endmodule

`default_nettype wire
